>>> rtl/ggt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ggt_pkg;

   localparam int PW    = 32;
   localparam int GW    = 50;
   localparam int KW    = 52;
   localparam int SW    = 64;
   localparam int IPW   = 66;
   localparam int IPMW  = 64;
   localparam int MW    = 96;
   localparam int TPW   = 97;
   localparam int CW    = 98;
   localparam int CMW   = 96;
   localparam int S2W   = 128;
   localparam int S4W   = 256;
   localparam int S5W   = 320;
   localparam int AW    = 148;
   localparam int ASW   = 296;
   localparam int ASH   = 48;
   localparam int RW    = 344;
   localparam int UW    = 332;
   localparam int DW    = 449;
   localparam int QW    = 65;
   localparam int TW    = 64;
   localparam int L1    = 1;
   localparam int L2    = 2;
   localparam int L3    = 3;

   localparam logic [GW-1:0] GP_RESET = 50'd398600441800000;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic [2:0][1:0] neg;
      logic [SW-1:0]   s;
      logic [KW-1:0]   kmu;
      logic            zero;
   } p1_side_type;

   typedef struct packed {
      logic [2:0]    neg;
      logic [SW-1:0] s;
      logic          zero;
   } p2_side_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } p3_side_type;

   typedef struct packed {
      logic [RW-1:0] r;
      logic [UW-1:0] u;
      logic [QW-1:0] q;
   } rlane_type;

   typedef struct packed {
      logic [S5W-1:0]  s5;
      rlane_type [2:0] lane;
      logic [2:0]      neg;
      logic            zero;
   } root_type;

   typedef struct packed {
      logic [2:0][TW-1:0] torque;
      logic [1:0]         status;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/ggt_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module ggt_mul #(
   parameter int WA  = 32,
   parameter int WB  = 32,
   parameter int LVL = 0,
   parameter int WS  = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WA-1:0]    a,
   input  logic [WB-1:0]    b,
   input  logic [WS-1:0]    side_i,
   output logic [WA+WB-1:0] p,
   output logic [WS-1:0]    side_o
);

   localparam int NA  = (WA + 31) / 32;
   localparam int NB  = (WB + 31) / 32;
   localparam int AXW = NA * 32;
   localparam int BXW = NB * 32;
   localparam int WP  = (NA + NB) * 32;
   localparam int NL  = 2 ** LVL;
   localparam int NN  = 2 * NL - 1;

   logic [AXW-1:0] ax;
   logic [BXW-1:0] bx;
   logic [63:0]    pp_ff [NB][NA];
   logic [WP-1:0]  ev [NB];
   logic [WP-1:0]  od [NB];
   logic [WP-1:0]  lf [NL];
   logic [WP-1:0]  hp_ff [NN];
   logic [WS-1:0]  sd_ff [LVL+2];

   assign ax = AXW'(a);
   assign bx = BXW'(b);

   // limb products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NB; j++) begin
            for (int i = 0; i < NA; i++) begin
               pp_ff[j][i] <= ax[32*i +: 32] * bx[32*j +: 32];
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < NB; j++) begin
         ev[j] = '0;
         od[j] = '0;
         for (int i = 0; i < NA; i++) begin
            if (i % 2 == 0) begin
               ev[j] = ev[j] | (WP'(pp_ff[j][i]) << (32 * i));
            end else begin
               od[j] = od[j] | (WP'(pp_ff[j][i]) << (32 * i));
            end
         end
      end
   end

   for (genvar j = 0; j < NL; j++) begin : g_lf
      if (j < NB) begin : g_row
         assign lf[j] = WP'((ev[j] + od[j]) << (32 * j));
      end else begin : g_pad
         assign lf[j] = '0;
      end
   end

   // registered adder tree, root at node 0
   for (genvar n = 0; n < NN; n++) begin : g_hp
      if (n >= NL - 1) begin : g_leaf
         always_ff @(posedge clock) begin
            if (en) begin
               hp_ff[n] <= lf[n-(NL-1)];
            end
         end
      end else begin : g_node
         always_ff @(posedge clock) begin
            if (en) begin
               hp_ff[n] <= hp_ff[2*n+1] + hp_ff[2*n+2];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= side_i;
         for (int k = 1; k < LVL + 2; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   assign p      = hp_ff[0][WA+WB-1:0];
   assign side_o = sd_ff[LVL+1];

endmodule

`default_nettype wire

>>> rtl/ggt_root.sv
`timescale 1ns / 1ps
`default_nettype none

module ggt_root
   import ggt_pkg::*;
#(
   parameter int BIT = 0
) (
   input  logic     clock,
   input  logic     en,
   input  root_type rt_i,
   output root_type rt_o
);

   root_type      rt_in;
   root_type      rt_ff;
   logic [DW-1:0] rx [3];
   logic [DW-1:0] dlt [3];
   logic          ok [3];

   // try one more quotient bit: (q + 2^b)^2 * s^5 <= a^2
   always_comb begin
      rt_in = rt_i;
      for (int i = 0; i < 3; i++) begin
         rx[i]  = DW'(rt_i.lane[i].r);
         dlt[i] = (DW'(rt_i.lane[i].u) << (BIT + 1)) + (DW'(rt_i.s5) << (2 * BIT));
         ok[i]  = rx[i] >= dlt[i];
         if (ok[i]) begin
            rt_in.lane[i].r = RW'(rx[i] - dlt[i]);
            rt_in.lane[i].u = UW'(DW'(rt_i.lane[i].u) + (DW'(rt_i.s5) << BIT));
            rt_in.lane[i].q = rt_i.lane[i].q | (QW'(1) << BIT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt_ff <= rt_in;
      end
   end

   assign rt_o = rt_ff;

endmodule

`default_nettype wire

>>> rtl/gravity_gradient_torque_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// gravity gradient torque, T = 3*mu * (p x (I*p)) / |p|^5, Q24.40 output
// req channel: position (whole metres) and inertia tensor (Q16.16, row major),
//   a transaction is taken when req_valid is high and req_stall is low
// rsp channel: three torque components and a status code, taken when
//   rsp_valid is high and rsp_stall is low
// csr port: csr_we writes csr_wdata into the gravitational parameter
// a new transaction can enter every cycle while req_stall is low
// the pipeline consists of the product pipelines (limb products and adder trees)
//   and the 65-stage bit-per-stage root, one torque bit per stage
// a stalled receiver lets the pipeline push one more result into a skid
//   register, after which req_stall rises and the whole pipeline holds
// reset empties the pipeline and loads the earth value of the parameter
// zero position gives zero torque with status 1, a clipped torque status 2

module gravity_gradient_torque_unit
   import ggt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_pos_z,
   input  logic signed [31:0]   req_inertia_xx,
   input  logic signed [31:0]   req_inertia_xy,
   input  logic signed [31:0]   req_inertia_xz,
   input  logic signed [31:0]   req_inertia_yx,
   input  logic signed [31:0]   req_inertia_yy,
   input  logic signed [31:0]   req_inertia_yz,
   input  logic signed [31:0]   req_inertia_zx,
   input  logic signed [31:0]   req_inertia_zy,
   input  logic signed [31:0]   req_inertia_zz,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [63:0]   rsp_torque_x,
   output logic signed [63:0]   rsp_torque_y,
   output logic signed [63:0]   rsp_torque_z,
   output logic [1:0]           rsp_status,
   input  logic                 csr_we,
   input  logic [49:0]          csr_wdata
);

   localparam int DEPTH = 4 + (L1 + 2) + 3 + (L2 + 2) + (L3 + 2) + QW + 1;

   logic              adv;
   logic [DEPTH-1:0]  vld_ff;
   logic [GW-1:0]     mu_ff;

   logic signed [PW-1:0] rq_p [3];
   logic signed [PW-1:0] rq_i [3][3];

   logic signed [PW-1:0] s0_p_ff [3];
   logic signed [PW-1:0] s0_i_ff [3][3];
   logic [KW-1:0]        s0_kmu_ff;

   logic signed [63:0]   s1_pr_ff [3][3];
   logic [SW-1:0]        s1_sq_ff [3];
   logic signed [PW-1:0] s1_p_ff [3];
   logic [KW-1:0]        s1_kmu_ff;

   logic signed [IPW-1:0] s2_ip_ff [3];
   logic [SW-1:0]         s2_s_ff;
   logic signed [PW-1:0]  s2_p_ff [3];
   logic [KW-1:0]         s2_kmu_ff;

   logic [IPMW-1:0] s3_ipm_ff [3];
   logic            s3_ipn_ff [3];
   logic [PW-1:0]   s3_pm_ff [3];
   logic            s3_pn_ff [3];
   logic [SW-1:0]   s3_s_ff;
   logic [KW-1:0]   s3_kmu_ff;
   logic            s3_zero_ff;

   logic [MW-1:0]  m1 [3][2];
   logic [S2W-1:0] sq2;
   p1_side_type    p1s_i;
   p1_side_type    p1s_o;

   logic signed [TPW-1:0] x1_t_ff [3][2];
   logic [S2W-1:0]        x1_s2_ff;
   logic [SW-1:0]         x1_s_ff;
   logic [KW-1:0]         x1_kmu_ff;
   logic                  x1_zero_ff;

   logic signed [CW-1:0] x2_c_ff [3];
   logic [S2W-1:0]       x2_s2_ff;
   logic [SW-1:0]        x2_s_ff;
   logic [KW-1:0]        x2_kmu_ff;
   logic                 x2_zero_ff;

   logic [CMW-1:0] x3_cm_ff [3];
   logic [2:0]     x3_cn_ff;
   logic [S2W-1:0] x3_s2_ff;
   logic [SW-1:0]  x3_s_ff;
   logic [KW-1:0]  x3_kmu_ff;
   logic           x3_zero_ff;

   logic [AW-1:0]  a0 [3];
   logic [S4W-1:0] sq4;
   p2_side_type    p2s_i;
   p2_side_type    p2s_o;

   logic [ASW-1:0] asq [3];
   logic [S5W-1:0] sq5;
   p3_side_type    p3s_i;
   p3_side_type    p3s_o;

   root_type rt [QW+1];

   logic [QW-1:0] lim [3];
   logic [QW-1:0] mag [3];
   logic          sat [3];
   rsp_type       fin_in;
   rsp_type       fin_ff;
   rsp_type       skid_ff;
   rsp_type       out_ff;
   logic          skid_vld_ff;
   logic          out_vld_ff;

   assign rq_p[0]    = req_pos_x;
   assign rq_p[1]    = req_pos_y;
   assign rq_p[2]    = req_pos_z;
   assign rq_i[0][0] = req_inertia_xx;
   assign rq_i[0][1] = req_inertia_xy;
   assign rq_i[0][2] = req_inertia_xz;
   assign rq_i[1][0] = req_inertia_yx;
   assign rq_i[1][1] = req_inertia_yy;
   assign rq_i[1][2] = req_inertia_yz;
   assign rq_i[2][0] = req_inertia_zx;
   assign rq_i[2][1] = req_inertia_zy;
   assign rq_i[2][2] = req_inertia_zz;

   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff <= GP_RESET;
      end else if (csr_we) begin
         mu_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // front end: 3*mu, I*p, |p|^2, magnitudes
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_p_ff   <= rq_p;
         s0_i_ff   <= rq_i;
         s0_kmu_ff <= {1'b0, mu_ff, 1'b0} + KW'(mu_ff);

         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               s1_pr_ff[i][j] <= s0_i_ff[i][j] * s0_p_ff[j];
            end
            s1_sq_ff[i] <= SW'(s0_p_ff[i]) * SW'(s0_p_ff[i]);
         end
         s1_p_ff   <= s0_p_ff;
         s1_kmu_ff <= s0_kmu_ff;

         for (int i = 0; i < 3; i++) begin
            s2_ip_ff[i] <= IPW'(s1_pr_ff[i][0]) + IPW'(s1_pr_ff[i][1])
                           + IPW'(s1_pr_ff[i][2]);
         end
         s2_s_ff   <= s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];
         s2_p_ff   <= s1_p_ff;
         s2_kmu_ff <= s1_kmu_ff;

         for (int i = 0; i < 3; i++) begin
            s3_ipm_ff[i] <= s2_ip_ff[i][IPW-1] ? IPMW'(-s2_ip_ff[i]) : IPMW'(s2_ip_ff[i]);
            s3_ipn_ff[i] <= s2_ip_ff[i][IPW-1];
            s3_pm_ff[i]  <= s2_p_ff[i][PW-1] ? PW'(-s2_p_ff[i]) : PW'(s2_p_ff[i]);
            s3_pn_ff[i]  <= s2_p_ff[i][PW-1];
         end
         s3_s_ff    <= s2_s_ff;
         s3_kmu_ff  <= s2_kmu_ff;
         s3_zero_ff <= s2_s_ff == '0;
      end
   end

   // cross product terms and |p|^4
   for (genvar i = 0; i < 3; i++) begin : g_cross
      localparam int IA = (i + 1) % 3;
      localparam int IB = (i + 2) % 3;

      ggt_mul #(.WA(IPMW), .WB(PW), .LVL(L1), .WS(1)) u_m0 (
         .clock  (clock),
         .en     (adv),
         .a      (s3_ipm_ff[IB]),
         .b      (s3_pm_ff[IA]),
         .side_i (1'b0),
         .p      (m1[i][0]),
         .side_o ()
      );

      ggt_mul #(.WA(IPMW), .WB(PW), .LVL(L1), .WS(1)) u_m1 (
         .clock  (clock),
         .en     (adv),
         .a      (s3_ipm_ff[IA]),
         .b      (s3_pm_ff[IB]),
         .side_i (1'b0),
         .p      (m1[i][1]),
         .side_o ()
      );

      assign p1s_i.neg[i][0] = s3_pn_ff[IA] ^ s3_ipn_ff[IB];
      assign p1s_i.neg[i][1] = s3_pn_ff[IB] ^ s3_ipn_ff[IA];
   end

   assign p1s_i.s    = s3_s_ff;
   assign p1s_i.kmu  = s3_kmu_ff;
   assign p1s_i.zero = s3_zero_ff;

   ggt_mul #(.WA(SW), .WB(SW), .LVL(L1), .WS($bits(p1_side_type))) u_sq2 (
      .clock  (clock),
      .en     (adv),
      .a      (s3_s_ff),
      .b      (s3_s_ff),
      .side_i (p1s_i),
      .p      (sq2),
      .side_o (p1s_o)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 2; k++) begin
               x1_t_ff[i][k] <= p1s_o.neg[i][k] ? -$signed(TPW'(m1[i][k]))
                                                : $signed(TPW'(m1[i][k]));
            end
         end
         x1_s2_ff   <= sq2;
         x1_s_ff    <= p1s_o.s;
         x1_kmu_ff  <= p1s_o.kmu;
         x1_zero_ff <= p1s_o.zero;

         for (int i = 0; i < 3; i++) begin
            x2_c_ff[i] <= CW'(x1_t_ff[i][0]) - CW'(x1_t_ff[i][1]);
         end
         x2_s2_ff   <= x1_s2_ff;
         x2_s_ff    <= x1_s_ff;
         x2_kmu_ff  <= x1_kmu_ff;
         x2_zero_ff <= x1_zero_ff;

         for (int i = 0; i < 3; i++) begin
            x3_cm_ff[i] <= x2_c_ff[i][CW-1] ? CMW'(-x2_c_ff[i]) : CMW'(x2_c_ff[i]);
            x3_cn_ff[i] <= x2_c_ff[i][CW-1];
         end
         x3_s2_ff   <= x2_s2_ff;
         x3_s_ff    <= x2_s_ff;
         x3_kmu_ff  <= x2_kmu_ff;
         x3_zero_ff <= x2_zero_ff;
      end
   end

   // numerator scale and |p|^8
   for (genvar i = 0; i < 3; i++) begin : g_scale
      ggt_mul #(.WA(CMW), .WB(KW), .LVL(L2), .WS(1)) u_a0 (
         .clock  (clock),
         .en     (adv),
         .a      (x3_cm_ff[i]),
         .b      (x3_kmu_ff),
         .side_i (1'b0),
         .p      (a0[i]),
         .side_o ()
      );
   end

   assign p2s_i.neg  = x3_cn_ff;
   assign p2s_i.s    = x3_s_ff;
   assign p2s_i.zero = x3_zero_ff;

   ggt_mul #(.WA(S2W), .WB(S2W), .LVL(L2), .WS($bits(p2_side_type))) u_sq4 (
      .clock  (clock),
      .en     (adv),
      .a      (x3_s2_ff),
      .b      (x3_s2_ff),
      .side_i (p2s_i),
      .p      (sq4),
      .side_o (p2s_o)
   );

   // squared numerator and |p|^10
   for (genvar i = 0; i < 3; i++) begin : g_asq
      ggt_mul #(.WA(AW), .WB(AW), .LVL(L3), .WS(1)) u_asq (
         .clock  (clock),
         .en     (adv),
         .a      (a0[i]),
         .b      (a0[i]),
         .side_i (1'b0),
         .p      (asq[i]),
         .side_o ()
      );
   end

   assign p3s_i.neg  = p2s_o.neg;
   assign p3s_i.zero = p2s_o.zero;

   ggt_mul #(.WA(S4W), .WB(SW), .LVL(L3), .WS($bits(p3_side_type))) u_sq5 (
      .clock  (clock),
      .en     (adv),
      .a      (sq4),
      .b      (p2s_o.s),
      .side_i (p3s_i),
      .p      (sq5),
      .side_o (p3s_o)
   );

   // one result bit per stage, msb first
   always_comb begin
      rt[0].s5   = sq5;
      rt[0].neg  = p3s_o.neg;
      rt[0].zero = p3s_o.zero;
      for (int i = 0; i < 3; i++) begin
         rt[0].lane[i].r = {asq[i], {ASH{1'b0}}};
         rt[0].lane[i].u = '0;
         rt[0].lane[i].q = '0;
      end
   end

   for (genvar n = 0; n < QW; n++) begin : g_root
      ggt_root #(.BIT(QW - 1 - n)) u_root (
         .clock (clock),
         .en    (adv),
         .rt_i  (rt[n]),
         .rt_o  (rt[n+1])
      );
   end

   // sign, saturation and status
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lim[i] = rt[QW].neg[i] ? (QW'(1) << (TW - 1)) : ((QW'(1) << (TW - 1)) - QW'(1));
         sat[i] = rt[QW].lane[i].q > lim[i];
         mag[i] = sat[i] ? lim[i] : rt[QW].lane[i].q;
         if (rt[QW].zero) begin
            fin_in.torque[i] = '0;
         end else if (rt[QW].neg[i]) begin
            fin_in.torque[i] = TW'(QW'(0) - mag[i]);
         end else begin
            fin_in.torque[i] = TW'(mag[i]);
         end
      end
      if (rt[QW].zero) begin
         fin_in.status = ST_ZERO;
      end else if (sat[0] || sat[1] || sat[2]) begin
         fin_in.status = ST_SAT;
      end else begin
         fin_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff <= fin_in;
      end
   end

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || !rsp_stall) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= vld_ff[DEPTH-1];
         end
      end else if (!skid_vld_ff) begin
         skid_vld_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || !rsp_stall) begin
         out_ff <= skid_vld_ff ? skid_ff : fin_ff;
      end else if (!skid_vld_ff) begin
         skid_ff <= fin_ff;
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_torque_x = out_ff.torque[0];
   assign rsp_torque_y = out_ff.torque[1];
   assign rsp_torque_z = out_ff.torque[2];
   assign rsp_status   = out_ff.status;

endmodule

`default_nettype wire

>>> tb/tb_gravity_gradient_torque_unit.sv
`timescale 1ns / 1ps

module tb_gravity_gradient_torque_unit;
   import ggt_pkg::*;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [8:0][31:0] inr;
   } ggt_item_type;

   typedef struct {
      ggt_item_type item;
      bit           known;
      rsp_type      torque_exp;
   } ggt_row_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic [63:0] POS_LIM = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;
   localparam logic [31:0] I32_MAX = 32'h7fff_ffff;
   localparam logic [31:0] I32_MIN = 32'h8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ggt_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [63:0] rsp_torque_x, rsp_torque_y, rsp_torque_z;
   logic [1:0] rsp_status;
   logic csr_we = 1'b0;
   logic [49:0] csr_wdata = '0;

   logic [49:0] mu_model = GP_RESET;
   ggt_row_type sent_rows[$];
   rsp_type torque_pending[$];
   int mismatch_count = 0;
   int item_count = 0;
   int result_count = 0;
   int sat_count = 0;
   int zero_count = 0;
   int mu_settings = 1;
   int idle_count = 0;
   int stall_left = 0;
   int stall_pick;
   bit quiet_mode = 1'b0;

   gravity_gradient_torque_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pos_x(req_item.pos[0]),
      .req_pos_y(req_item.pos[1]),
      .req_pos_z(req_item.pos[2]),
      .req_inertia_xx(req_item.inr[0]),
      .req_inertia_xy(req_item.inr[1]),
      .req_inertia_xz(req_item.inr[2]),
      .req_inertia_yx(req_item.inr[3]),
      .req_inertia_yy(req_item.inr[4]),
      .req_inertia_yz(req_item.inr[5]),
      .req_inertia_zx(req_item.inr[6]),
      .req_inertia_zy(req_item.inr[7]),
      .req_inertia_zz(req_item.inr[8]),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_torque_x(rsp_torque_x),
      .rsp_torque_y(rsp_torque_y),
      .rsp_torque_z(rsp_torque_z),
      .rsp_status(rsp_status),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rsp_type predict_torque(ggt_item_type it, logic [49:0] mu);
      logic signed [129:0] p[3];
      logic signed [129:0] ip[3];
      logic signed [129:0] cr[3];
      logic [129:0] mag;
      logic [399:0] ssum, s5, kk, num, quo;
      logic [127:0] q128, sq, tr;
      logic [63:0] root, lim;
      bit neg, sat;
      rsp_type r;
      sat = 1'b0;
      ssum = '0;
      for (int i = 0; i < 3; i++) begin
         p[i] = $signed(it.pos[i]);
         ssum = ssum + 400'(p[i] * p[i]);
      end
      if (ssum == 0) begin
         r.torque = '0;
         r.status = ST_ZERO;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         ip[i] = '0;
         for (int j = 0; j < 3; j++)
            ip[i] = ip[i] + 130'($signed(it.inr[3 * i + j])) * p[j];
      end
      cr[0] = p[1] * ip[2] - p[2] * ip[1];
      cr[1] = p[2] * ip[0] - p[0] * ip[2];
      cr[2] = p[0] * ip[1] - p[1] * ip[0];
      s5 = ssum * ssum * ssum * ssum * ssum;
      kk = (400'(mu) * 400'd3) << 24;
      for (int i = 0; i < 3; i++) begin
         neg = cr[i] < 0;
         mag = neg ? -cr[i] : cr[i];
         num = 400'(mag) * kk;
         num = num * num;
         quo = num / s5;
         lim = neg ? NEG_LIM : POS_LIM;
         if (quo[399:128] != 0) begin
            sat = 1'b1;
            r.torque[i] = lim;
         end else begin
            q128 = quo[127:0];
            root = '0;
            for (int b = 63; b >= 0; b--) begin
               tr = 128'(root | (64'd1 << b));
               sq = tr * tr;
               if (sq <= q128)
                  root = tr[63:0];
            end
            if (root > lim) begin
               sat = 1'b1;
               r.torque[i] = lim;
            end else begin
               r.torque[i] = neg ? -root : root;
            end
         end
      end
      r.status = sat ? ST_SAT : ST_OK;
      return r;
   endfunction

   function automatic logic [31:0] rand_scaled();
      logic [31:0] v;
      v = $urandom >> $urandom_range(0, 31);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic ggt_item_type random_item();
      ggt_item_type it;
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++)
         it.pos[i] = rand_scaled();
      for (int i = 0; i < 9; i++)
         it.inr[i] = rand_scaled();
      if (kind < 5) begin
         // plausible body: positive diagonal, random scaled products of inertia
         for (int i = 0; i < 3; i++) begin
            it.inr[4 * i] = $urandom_range(1 << 16, 32'h3fff_ffff);
            it.pos[i] = $signed($urandom_range(0, 80_000_000)) - 40_000_000;
         end
      end else if (kind < 7) begin
         for (int i = 0; i < 3; i++)
            it.pos[i] = $urandom;
         for (int i = 0; i < 9; i++)
            it.inr[i] = $urandom;
      end else if (kind == 7) begin
         for (int i = 0; i < 3; i++)
            it.pos[i] = $signed($urandom_range(0, 6)) - 3;
      end else if (kind == 8) begin
         if ($urandom_range(0, 3) == 0)
            it.pos = '0;
         else
            it.pos[$urandom_range(0, 2)] = $urandom_range(0, 1) ? I32_MIN : I32_MAX;
      end
      return it;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_row(ggt_row_type row);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      sent_rows.push_back(row);
      req_item <= row.item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_random(int n);
      ggt_row_type row;
      row.known = 1'b0;
      row.torque_exp = '0;
      for (int k = 0; k < n; k++) begin
         row.item = random_item();
         send_row(row);
      end
      req_valid <= 1'b0;
   endtask

   task automatic write_mu(logic [49:0] value);
      while (torque_pending.size() != 0 || sent_rows.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      mu_model = value;
      mu_settings++;
   endtask

   // accepted request transaction: queue the expected torque
   always @(posedge clock) begin
      ggt_row_type row;
      if (!reset && req_valid && !req_stall) begin
         row = sent_rows.pop_front();
         item_count++;
         torque_pending.push_back(row.known ? row.torque_exp
                                            : predict_torque(req_item, mu_model));
      end
   end

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (rsp_status == ST_SAT)
            sat_count++;
         if (rsp_status == ST_ZERO)
            zero_count++;
         if (torque_pending.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transaction at %0t", $realtime);
         end else begin
            exp_r = torque_pending.pop_front();
            if (rsp_torque_x !== exp_r.torque[0] || rsp_torque_y !== exp_r.torque[1] ||
                rsp_torque_z !== exp_r.torque[2] || rsp_status !== exp_r.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: exp %h %h %h st %0d, got %h %h %h st %0d",
                           $realtime, exp_r.torque[0], exp_r.torque[1], exp_r.torque[2],
                           exp_r.status, rsp_torque_x, rsp_torque_y, rsp_torque_z,
                           rsp_status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (quiet_mode) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 70) begin
            rsp_stall <= 1'b0;
         end else if (stall_pick < 96) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_count);
         $display("gravity_gradient_torque_unit verification failed");
         $finish;
      end
   end

   initial begin
      ggt_row_type directed_rows[$];
      ggt_row_type row;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero distance, any tensor
      row.item = '0;
      row.item.inr = {9{I32_MAX}};
      row.known = 1'b1;
      row.torque_exp.torque = '0;
      row.torque_exp.status = ST_ZERO;
      directed_rows.push_back(row);
      row.item.inr = {9{I32_MIN}};
      directed_rows.push_back(row);
      // zero tensor gives zero torque
      row.item.inr = '0;
      row.item.pos = {I32_MIN, I32_MAX, I32_MIN};
      row.torque_exp.status = ST_OK;
      directed_rows.push_back(row);
      row.item.pos = {32'd1, 32'd0, 32'd0};
      directed_rows.push_back(row);
      // isotropic tensor: I*p parallel to p
      row.item.pos = {I32_MAX, I32_MIN, 32'd12345};
      row.item.inr = {I32_MAX, 32'd0, 32'd0, 32'd0, I32_MAX, 32'd0, 32'd0, 32'd0, I32_MAX};
      directed_rows.push_back(row);
      // saturating negative and positive z torque
      row.item.pos = {32'd0, 32'd1, 32'd1};
      row.item.inr = '0;
      row.item.inr[0] = I32_MAX;
      row.torque_exp.torque = {NEG_LIM, 64'd0, 64'd0};
      row.torque_exp.status = ST_SAT;
      directed_rows.push_back(row);
      row.item.inr = '0;
      row.item.inr[4] = I32_MAX;
      row.torque_exp.torque = {POS_LIM, 64'd0, 64'd0};
      directed_rows.push_back(row);
      // predicted rows: field extremes and typical values
      row.known = 1'b0;
      row.item.pos = {3{I32_MIN}};
      row.item.inr = {9{I32_MIN}};
      directed_rows.push_back(row);
      row.item.pos = {I32_MIN, I32_MAX, I32_MIN};
      row.item.inr = {I32_MAX, I32_MIN, I32_MAX, I32_MIN, I32_MAX,
                      I32_MIN, I32_MAX, I32_MIN, I32_MAX};
      directed_rows.push_back(row);
      row.item.pos = {32'd0, 32'd0, 32'd6_771_000};
      row.item.inr = {32'd10 << 16, 32'd1 << 12, 32'd2 << 12, 32'd3 << 12, 32'd12 << 16,
                      32'd5 << 12, 32'd7 << 12, 32'd11 << 12, 32'd8 << 16};
      directed_rows.push_back(row);
      row.item.pos = {32'd4_000_000, -32'd3_000_000, 32'd2_500_000};
      directed_rows.push_back(row);
      row.item.pos = {32'hffff_ffff, 32'd1, 32'hffff_ffff};
      row.item.inr = {9{32'hffff_ffff}};
      directed_rows.push_back(row);
      row.item.inr = {9{32'h5555_aaaa}};
      directed_rows.push_back(row);

      foreach (directed_rows[k])
         send_row(directed_rows[k]);
      req_valid <= 1'b0;

      send_random(250);
      quiet_mode = 1'b1;
      send_random(150);
      quiet_mode = 1'b0;
      write_mu({50{1'b1}});
      send_random(250);
      write_mu('0);
      send_random(100);
      write_mu(50'd1);
      send_random(200);
      for (int k = 0; k < 3; k++) begin
         write_mu({$urandom, $urandom} & {50{1'b1}});
         send_random(180);
      end
      write_mu(GP_RESET);
      send_random(100);

      while (torque_pending.size() != 0 || sent_rows.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      $display("%0d request and %0d result transactions, %0d parameter values",
               item_count, result_count, mu_settings);
      $display("%0d saturated and %0d zero distance results", sat_count, zero_count);
      if (mismatch_count == 0 && torque_pending.size() == 0)
         $display("gravity_gradient_torque_unit verification clean");
      else
         $display("gravity_gradient_torque_unit verification failed");
      $finish;
   end

endmodule
